// ===== src/fscl_pkg.sv =====
// Shared types and constants for the FIFO-replacement sector cache lookup.
// Depends on nothing; all other source files but fscl_ram use it by scoped names.
package fscl_pkg;

    // Geometry (SECTOR_BYTES, SLOTS and MAP_SECTORS are powers of two)
    localparam int SECTOR_BYTES = 512;
    localparam int SLOTS        = 32;
    localparam int MAP_SECTORS  = 65536;

    // Fixed field widths of the words on the ports
    localparam int POS_W   = 25;
    localparam int DSEC_W  = 32;
    localparam int ADDR_W  = 14;
    localparam int FSLOT_W = 5;

    // Derived widths
    localparam int OFF_W  = $clog2(SECTOR_BYTES);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int MAP_W  = $clog2(MAP_SECTORS);
    localparam int SMAP_W = SLOT_W + 1;   // valid bit over slot index

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [POS_W-1:0]  rom_position;
        logic [DSEC_W-1:0] disk_sector;
    } t_in_word;

    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  buffer_address;
        logic               fill_needed;
        logic [DSEC_W-1:0]  fill_disk_sector;
        logic [FSLOT_W-1:0] fill_slot;
    } t_out_word;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UNMAP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // input word taken this cycle
        logic clear_step;  // clear one sector map entry
        logic lookup;      // resolve hit/miss and load the result register
        logic unmap;       // drop the victim's previous owner from the map
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_read;     // word on the input is an in-range read
        logic hit;         // looked-up sector owns a slot
        logic old_valid;   // victim slot has a previous owner
        logic out_free;    // result register can take a word
        logic clear_last;  // last entry of the clearing pass
    } t_status;

endpackage

// ===== src/fscl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; read data holds while the port is not enabled for a read.
module fscl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fscl_datapath.sv =====
// Datapath: disk sector map, sector-to-slot map, slot owner table,
// replace pointer and result register. Uses fscl_pkg and fscl_ram.
module fscl_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fscl_pkg::t_in_word  i_in_word,
    input  fscl_pkg::t_cmd      i_cmd,
    input  logic                i_out_stall,
    output fscl_pkg::t_status   o_status,
    output logic                o_out_valid,
    output fscl_pkg::t_out_word o_out_word
);

    localparam int MAP_W  = fscl_pkg::MAP_W;
    localparam int SLOT_W = fscl_pkg::SLOT_W;
    localparam int OFF_W  = fscl_pkg::OFF_W;
    localparam int SMAP_W = fscl_pkg::SMAP_W;

    logic [31:0]               idx_full;
    logic                      in_range;
    logic [MAP_W-1:0]          in_addr;
    logic                      is_read;

    logic [MAP_W-1:0]          r_idx;
    logic [OFF_W-1:0]          r_off;
    logic [SLOT_W-1:0]         r_rp;
    logic [SLOT_W-1:0]         n_rp;
    logic [fscl_pkg::SLOTS-1:0] r_owner_valid;
    logic [MAP_W-1:0]          r_clr_cnt;
    logic                      r_out_valid;
    fscl_pkg::t_out_word       r_out_word;

    logic                      dmap_en;
    logic                      dmap_we;
    logic [fscl_pkg::DSEC_W-1:0] dmap_rd;

    logic                      smap_en;
    logic                      smap_we;
    logic [MAP_W-1:0]          smap_addr;
    logic [SMAP_W-1:0]         smap_wd;
    logic [SMAP_W-1:0]         smap_rd;

    logic                      own_en;
    logic                      own_we;
    logic [MAP_W-1:0]          own_rd;

    logic                      hit;
    logic                      miss_write;
    logic [SLOT_W-1:0]         slot;
    logic [31:0]               addr_full;
    logic [31:0]               fslot_full;

    // Split the byte position into sector index and offset
    assign idx_full = 32'(i_in_word.rom_position >> OFF_W);
    assign in_range = idx_full < 32'(fscl_pkg::MAP_SECTORS);
    assign in_addr  = idx_full[MAP_W-1:0];
    assign is_read  = (i_in_word.opcode == fscl_pkg::OP_READ);

    // Disk sector map: written by loads, read by reads, both at accept
    assign dmap_en = i_cmd.accept && in_range;
    assign dmap_we = !is_read;

    fscl_ram #(
        .WIDTH (fscl_pkg::DSEC_W),
        .DEPTH (fscl_pkg::MAP_SECTORS)
    ) u_dmap (
        .i_clk   (i_clk),
        .i_en    (dmap_en),
        .i_we    (dmap_we),
        .i_addr  (in_addr),
        .i_wdata (i_in_word.disk_sector),
        .o_rdata (dmap_rd)
    );

    assign hit        = smap_rd[SMAP_W-1];
    assign miss_write = i_cmd.lookup && !hit;

    // Sector map port: clearing pass, lookup read, map on miss, unmap victim owner
    always_comb begin
        smap_en   = 1'b0;
        smap_we   = 1'b0;
        smap_addr = in_addr;
        smap_wd   = '0;
        if (i_cmd.clear_step) begin
            smap_en   = 1'b1;
            smap_we   = 1'b1;
            smap_addr = r_clr_cnt;
        end else if (i_cmd.accept) begin
            smap_en   = in_range && is_read;
        end else if (miss_write) begin
            smap_en   = 1'b1;
            smap_we   = 1'b1;
            smap_addr = r_idx;
            smap_wd   = {1'b1, r_rp};
        end else if (i_cmd.unmap) begin
            smap_en   = 1'b1;
            smap_we   = 1'b1;
            smap_addr = own_rd;
        end
    end

    fscl_ram #(
        .WIDTH (SMAP_W),
        .DEPTH (fscl_pkg::MAP_SECTORS)
    ) u_smap (
        .i_clk   (i_clk),
        .i_en    (smap_en),
        .i_we    (smap_we),
        .i_addr  (smap_addr),
        .i_wdata (smap_wd),
        .o_rdata (smap_rd)
    );

    // Slot owner table: victim owner read at accept, new owner written on miss
    assign own_en = (i_cmd.accept && in_range && is_read) || miss_write;
    assign own_we = miss_write;

    fscl_ram #(
        .WIDTH (MAP_W),
        .DEPTH (fscl_pkg::SLOTS)
    ) u_owner (
        .i_clk   (i_clk),
        .i_en    (own_en),
        .i_we    (own_we),
        .i_addr  (r_rp),
        .i_wdata (r_idx),
        .o_rdata (own_rd)
    );

    // Captured index and offset of the word in flight
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= in_addr;
            r_off <= i_in_word.rom_position[OFF_W-1:0];
        end
    end

    // Replace pointer with wrap
    assign n_rp = (r_rp == SLOT_W'(fscl_pkg::SLOTS - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp          <= '0;
            r_owner_valid <= '0;
        end else if (miss_write) begin
            r_rp                <= n_rp;
            r_owner_valid[r_rp] <= 1'b1;
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Result fields
    assign slot       = hit ? smap_rd[SLOT_W-1:0] : r_rp;
    assign addr_full  = (32'(slot) << OFF_W) | 32'(r_off);
    assign fslot_full = 32'(r_rp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.lookup) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_out_word.hit              <= hit;
            r_out_word.buffer_address   <= addr_full[fscl_pkg::ADDR_W-1:0];
            r_out_word.fill_needed      <= !hit;
            r_out_word.fill_disk_sector <= hit ? '0 : dmap_rd;
            r_out_word.fill_slot        <= hit ? '0 : fslot_full[fscl_pkg::FSLOT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Status to the controller
    assign o_status.in_read    = in_range && is_read;
    assign o_status.hit        = hit;
    assign o_status.old_valid  = r_owner_valid[r_rp];
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.clear_last = (r_clr_cnt == MAP_W'(fscl_pkg::MAP_SECTORS - 1));

endmodule

// ===== src/fscl_ctrl.sv =====
// Controller: sequences the clearing pass, accept, lookup and unmap steps.
// Uses fscl_pkg; drives commands into fscl_datapath.
module fscl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fscl_pkg::t_status i_status,
    output logic              o_in_stall,
    output fscl_pkg::t_cmd    o_cmd
);

    fscl_pkg::t_state r_state;
    fscl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fscl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fscl_pkg::S_CLEAR: begin
                if (i_status.clear_last) n_state = fscl_pkg::S_IDLE;
            end
            fscl_pkg::S_IDLE: begin
                if (i_in_valid && i_status.in_read) n_state = fscl_pkg::S_LOOKUP;
            end
            fscl_pkg::S_LOOKUP: begin
                if (i_status.out_free) begin
                    if (!i_status.hit && i_status.old_valid) begin
                        n_state = fscl_pkg::S_UNMAP;
                    end else begin
                        n_state = fscl_pkg::S_IDLE;
                    end
                end
            end
            fscl_pkg::S_UNMAP: begin
                n_state = fscl_pkg::S_IDLE;
            end
            default: begin
                n_state = fscl_pkg::S_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            fscl_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            fscl_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            fscl_pkg::S_LOOKUP: begin
                o_cmd.lookup = i_status.out_free;
            end
            fscl_pkg::S_UNMAP: begin
                o_cmd.unmap = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/fifo_sector_cache_lookup_top.sv =====
// Top level of the FIFO-replacement sector cache lookup.
// Uses fscl_pkg, fscl_ctrl and fscl_datapath.
//
//   channel | handshake               | word
//   --------+-------------------------+----------------------------
//   input   | i_in_valid / o_in_stall | t_in_word  (opcode, position, sector)
//   output  | o_out_valid / i_out_stall | t_out_word (hit, address, fill)
//
// A map load is taken in idle; a read is accepted in idle, resolved in lookup,
// and, on a miss whose victim slot had an owner, passes through unmap (that
// step is the second write to the single-port sector-to-slot map). One word is
// in work at a time. After reset the sector-to-slot map is cleared, one entry a
// cycle, over all MAP_SECTORS (65536) entries, with o_in_stall high.
// A finished result waits in the output register; a read whose result
// register is still stalled holds in lookup until it frees.
module fifo_sector_cache_lookup_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fscl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fscl_pkg::t_out_word o_out_word
);

    fscl_pkg::t_cmd    cmd;
    fscl_pkg::t_status status;

    fscl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fscl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== src/fscl_checker.sv =====
// Port-level checks for the sector cache lookup, bound to the top level.
// Uses fscl_pkg for the word types.
module fscl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fscl_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fscl_pkg::t_out_word o_out_word
);

    // Coming out of reset the block is clearing and takes no word
    a_stall_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> o_in_stall)
        else $error("input not stalled right after reset");

    // An accepted read keeps the input stalled while it is looked up
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.opcode == fscl_pkg::OP_READ)
        |=> o_in_stall)
        else $error("read accepted without a busy cycle");

    // A new result appears only at the end of a busy lookup cycle
    a_result_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a lookup");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

endmodule

bind fifo_sector_cache_lookup_top fscl_checker u_fscl_checker (.*);

// ===== test/tb_fifo_sector_cache_lookup_top.sv =====
// Testbench for the FIFO-replacement sector cache lookup top level.
// Depends on fscl_pkg and fifo_sector_cache_lookup_top; predicts every read word
// with its own copy of the sector map, slot tags and replace pointer.
module tb_fifo_sector_cache_lookup_top;

    localparam int POOL_SIZE = 48;
    localparam int HOT_SIZE  = 16;
    localparam int CALM_TAIL = 60;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    fscl_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    fscl_pkg::t_out_word o_out_word;

    // Predicted copy of the cache state
    logic [fscl_pkg::DSEC_W-1:0] dsec_table [fscl_pkg::MAP_SECTORS];
    logic [fscl_pkg::SMAP_W-1:0] slot_link  [fscl_pkg::MAP_SECTORS]; // valid over slot
    int unsigned                 slot_tag   [fscl_pkg::SLOTS];
    bit                          tag_valid  [fscl_pkg::SLOTS];
    int unsigned                 next_victim;

    // Sectors whose disk sector entry has been written
    bit        sector_loaded [int unsigned];

    fscl_pkg::t_out_word expected_lookups [$];
    int                  mismatch_count;
    bit                  calm;

    fifo_sector_cache_lookup_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit: covers the clearing pass plus a slow run several times over
    initial begin
        #(8 * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Predict the effect of one accepted word; reads queue one expected word
    function automatic void compute_lookup(input fscl_pkg::t_in_word w);
        int unsigned         idx;
        int unsigned         off;
        int unsigned         slot;
        fscl_pkg::t_out_word res;
        idx = int'(w.rom_position) >> fscl_pkg::OFF_W;
        off = int'(w.rom_position) & (fscl_pkg::SECTOR_BYTES - 1);
        if (idx >= fscl_pkg::MAP_SECTORS) return;
        if (w.opcode == fscl_pkg::OP_LOAD) begin
            dsec_table[idx] = w.disk_sector;
            return;
        end
        res = '0;
        if (slot_link[idx][fscl_pkg::SLOT_W]) begin
            slot    = int'(slot_link[idx][fscl_pkg::SLOT_W-1:0]);
            res.hit = 1'b1;
        end else begin
            slot = next_victim;
            // drop the victim's previous owner, if it had one
            if (tag_valid[slot]) slot_link[slot_tag[slot]] = '0;
            slot_tag[slot]       = idx;
            tag_valid[slot]      = 1'b1;
            slot_link[idx]       = {1'b1, fscl_pkg::SLOT_W'(slot)};
            res.fill_needed      = 1'b1;
            res.fill_disk_sector = dsec_table[idx];
            res.fill_slot        = fscl_pkg::FSLOT_W'(slot);
            next_victim          = (slot + 1 >= fscl_pkg::SLOTS) ? 0 : slot + 1;
        end
        res.buffer_address = fscl_pkg::ADDR_W'(slot * fscl_pkg::SECTOR_BYTES + off);
        expected_lookups.push_back(res);
    endfunction

    // Send one word; called and returning at a falling edge
    task automatic send_word(input fscl_pkg::t_in_word w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        compute_lookup(w);
        @(negedge i_clk);
    endtask

    task automatic load_sector(input int unsigned idx, input int unsigned off,
                               input logic [fscl_pkg::DSEC_W-1:0] dsec);
        fscl_pkg::t_in_word w;
        w.opcode       = fscl_pkg::OP_LOAD;
        w.rom_position = fscl_pkg::POS_W'(idx * fscl_pkg::SECTOR_BYTES + off);
        w.disk_sector  = dsec;
        sector_loaded[idx] = 1'b1;
        send_word(w);
    endtask

    task automatic read_at(input logic [fscl_pkg::POS_W-1:0] pos);
        fscl_pkg::t_in_word w;
        w.opcode       = fscl_pkg::OP_READ;
        w.rom_position = pos;
        w.disk_sector  = $urandom;
        send_word(w);
    endtask

    // First and last sector, all-zero and all-one fields, fresh victims
    task automatic test_position_extremes();
        load_sector(0, 0, 32'h0000_0000);
        load_sector(fscl_pkg::MAP_SECTORS - 1, fscl_pkg::SECTOR_BYTES - 1, 32'hFFFF_FFFF);
        read_at(25'h0000000);
        read_at(25'h1FFFFFF);
    endtask

    // Hits return the slot address with no fill request
    task automatic test_hits();
        read_at(25'h00001FF);
        read_at(25'h1FFFE00);
    endtask

    // Reloading the map of a cached sector keeps the slot mapped
    task automatic test_reload_cached();
        load_sector(0, 17, 32'hA5A5_5A5A);
        read_at(25'h0000010);
    endtask

    // Offset of a map load position is ignored
    task automatic test_unaligned_load();
        load_sector(16'h0123, 9'h1AB, 32'h1234_5678);
        read_at(fscl_pkg::POS_W'(16'h0123 * fscl_pkg::SECTOR_BYTES));
        read_at(fscl_pkg::POS_W'(16'h0123 * fscl_pkg::SECTOR_BYTES + 9'h1AB));
    endtask

    // Alternating bit patterns across the position field
    task automatic test_bit_patterns();
        load_sector(25'h0AAAAAA >> fscl_pkg::OFF_W,
                    25'h0AAAAAA & (fscl_pkg::SECTOR_BYTES - 1), 32'h5555_5555);
        load_sector(25'h1555555 >> fscl_pkg::OFF_W,
                    25'h1555555 & (fscl_pkg::SECTOR_BYTES - 1), 32'hAAAA_AAAA);
        read_at(25'h0AAAAAA);
        read_at(25'h1555555);
        read_at(25'h0AAAAAA);
    endtask

    // Mixed traffic over a working set larger than the slot count
    task automatic test_random_traffic(input int n);
        int unsigned pool [POOL_SIZE];
        int unsigned idx;
        int          pick;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool[k] = (k < POOL_SIZE / 2) ? $urandom_range(0, 63)
                                          : $urandom_range(0, fscl_pkg::MAP_SECTORS - 1);
        end
        for (int i = 0; i < n; i++) begin
            calm = (i >= n - CALM_TAIL);
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                // stray load anywhere in the map
                load_sector($urandom_range(0, fscl_pkg::MAP_SECTORS - 1),
                            $urandom_range(0, fscl_pkg::SECTOR_BYTES - 1), $urandom);
            end else begin
                idx = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, HOT_SIZE - 1)]
                                                 : pool[$urandom_range(0, POOL_SIZE - 1)];
                // reads only touch sectors with a written map entry
                if (pick < 30 || !sector_loaded.exists(idx)) begin
                    load_sector(idx, $urandom_range(0, fscl_pkg::SECTOR_BYTES - 1),
                                $urandom);
                end else begin
                    read_at(fscl_pkg::POS_W'(idx * fscl_pkg::SECTOR_BYTES
                                             + $urandom_range(0, fscl_pkg::SECTOR_BYTES - 1)));
                end
            end
        end
    endtask

    // Result stall: random bursts that never run back to back, none in the calm tail
    initial begin
        int burst_left;
        burst_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                burst_left = 0;
                i_out_stall <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (i_out_stall == 1'b0 && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 16) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        fscl_pkg::t_out_word exp_w;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_lookups.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: %p", o_out_word);
            end else begin
                exp_w = expected_lookups.pop_front();
                if (o_out_word.hit !== exp_w.hit
                    || o_out_word.buffer_address !== exp_w.buffer_address
                    || o_out_word.fill_needed !== exp_w.fill_needed
                    || o_out_word.fill_disk_sector !== exp_w.fill_disk_sector
                    || o_out_word.fill_slot !== exp_w.fill_slot) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p actual %p", exp_w, o_out_word);
                end
            end
        end
    end

    // Main sequence
    initial begin
        mismatch_count = 0;
        calm           = 1'b0;
        next_victim    = 0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        i_rst_n        = 1'b0;
        for (int k = 0; k < fscl_pkg::MAP_SECTORS; k++) begin
            slot_link[k]  = '0;
            dsec_table[k] = '0;
        end
        for (int k = 0; k < fscl_pkg::SLOTS; k++) begin
            slot_tag[k]  = 0;
            tag_valid[k] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_position_extremes();
        test_hits();
        test_reload_cached();
        test_unaligned_load();
        test_bit_patterns();
        test_random_traffic(450);

        i_in_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== fifo_sector_cache_lookup_top.f =====
src/fscl_pkg.sv
src/fscl_ram.sv
src/fscl_datapath.sv
src/fscl_ctrl.sv
src/fifo_sector_cache_lookup_top.sv
src/fscl_checker.sv
test/tb_fifo_sector_cache_lookup_top.sv
